// File: rtl/rrp_pkg.sv
`timescale 1ns / 1ps

package rrp_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	// Byte queue between the classifier and the parser.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Result queue; the parser needs room for two results before it takes a byte.
	localparam int RES_DEPTH = 4;
	localparam int RPTR_W    = $clog2(RES_DEPTH);

	localparam int REG_INDEX_W = 1;
	localparam logic [REG_INDEX_W-1:0] REG_MAX_BULK_LEN = 1'b0;
	localparam logic [REG_INDEX_W-1:0] REG_MAX_ELEMENTS = 1'b1;

	localparam logic [31:0] MAX_BULK_LEN_RST = 32'd536870912;
	localparam logic [31:0] MAX_ELEMENTS_RST = 32'd1048576;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;

	typedef struct packed {
		logic [7:0] c;
		logic       abandon;
		logic       is_digit;
		logic       is_letter;
		logic       is_ws;
		logic       is_cr;
		logic       is_lf;
		logic       is_sp;
		logic       is_star;
		logic       is_dollar;
		logic [3:0] digit;
	} byte_cls_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        has_byte;
		logic [31:0] element_index;
		logic        element_end;
		logic        message_end;
		logic        parse_error;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} result_push_t;

	function automatic byte_cls_t classify(input logic [7:0] c, input logic abandon);
		byte_cls_t k;
		k.c         = c;
		k.abandon   = abandon;
		k.is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
		k.is_letter = ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
		k.is_ws     = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
		k.is_cr     = (c == CH_CR);
		k.is_lf     = (c == CH_LF);
		k.is_sp     = (c == CH_SP);
		k.is_star   = (c == CH_STAR);
		k.is_dollar = (c == CH_DOLLAR);
		k.digit     = 4'(c - CH_ZERO);
		return k;
	endfunction

endpackage

// File: rtl/resp_request_parser_core.sv
`timescale 1ns / 1ps

// Byte-serial parser for request messages: array of bulk strings, a single
// bulk string, or an inline command split on spaces.
// Input side is a queue: drive in_byte and abandon with push while full is low.
// A byte with abandon set drops any partial message and gives no result.
// Result side is a queue: while empty is low the oldest result sits on the
// result ports, and pop takes it. One byte gives zero, one or two results;
// last_of_run marks the final result of a byte.
// Throughput is one byte per cycle while each byte gives at most one result and
// the receiver pops every cycle. An accepted byte is registered in the byte queue;
// the parser works on it at the head of that queue, and its results are written
// into the result queue, whose oldest entry drives the result ports.
// The parser takes a byte only when the result queue has two free slots, so
// a stalled receiver backs up into the byte queue and then raises full.
// Reset puts the parser in idle, empties both queues and loads the limit
// registers with their defaults. Limits are written through wr_en, wr_index
// and wr_data; the user must write them only while the block is idle (the block has no check).
module resp_request_parser_core #(
	parameter int LENGTH_BITS = rrp_pkg::LENGTH_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       in_byte,
	input  logic                             abandon,
	input  logic                             wr_en,
	input  logic [rrp_pkg::REG_INDEX_W-1:0]  wr_index,
	input  logic [31:0]                      wr_data,
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       out_byte,
	output logic                             has_byte,
	output logic [31:0]                      element_index,
	output logic                             element_end,
	output logic                             message_end,
	output logic                             parse_error,
	output logic                             last_of_run
);
	import rrp_pkg::*;

	logic          head_valid;
	byte_cls_t     head;
	logic          deq;
	logic          room;
	result_push_t  res_push;
	result_t       res_head;

	rrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.abandon    (abandon),
		.deq        (deq),
		.head_valid (head_valid),
		.head       (head)
	);

	rrp_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.head_valid (head_valid),
		.head       (head),
		.deq        (deq),
		.room       (room),
		.res_push   (res_push)
	);

	rrp_result_queue u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.room     (room),
		.pop      (pop),
		.empty    (empty),
		.head     (res_head)
	);

	assign out_byte      = res_head.out_byte;
	assign has_byte      = res_head.has_byte;
	assign element_index = res_head.element_index;
	assign element_end   = res_head.element_end;
	assign message_end   = res_head.message_end;
	assign parse_error   = res_head.parse_error;
	assign last_of_run   = res_head.last_of_run;

endmodule

// File: rtl/rrp_front.sv
`timescale 1ns / 1ps

module rrp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          in_byte,
	input  logic                abandon,
	input  logic                deq,
	output logic                head_valid,
	output rrp_pkg::byte_cls_t  head
);
	import rrp_pkg::*;

	byte_cls_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               do_push;
	logic               do_deq;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_deq     = deq && head_valid;

	// Bytes are classified on the way in so the parser sees flags beside the raw byte.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= classify(in_byte, abandon);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_deq);
		end
	end

endmodule

// File: rtl/rrp_back.sv
`timescale 1ns / 1ps

module rrp_back #(
	parameter int LENGTH_BITS = rrp_pkg::LENGTH_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [rrp_pkg::REG_INDEX_W-1:0]       wr_index,
	input  logic [31:0]                           wr_data,
	input  logic                                  head_valid,
	input  rrp_pkg::byte_cls_t                    head,
	output logic                                  deq,
	input  logic                                  room,
	output rrp_pkg::result_push_t                 res_push
);
	import rrp_pkg::*;

	localparam int AW = LENGTH_BITS;
	localparam int VW = ((AW > 32) ? AW : 32) + 4;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SIZE  = 3'd1;
	localparam logic [2:0] PH_MARK  = 3'd2;
	localparam logic [2:0] PH_DATA  = 3'd3;
	localparam logic [2:0] PH_TERM  = 3'd4;
	localparam logic [2:0] PH_PLAIN = 3'd5;

	localparam logic [1:0] FORM_NONE  = 2'd0;
	localparam logic [1:0] FORM_ARRAY = 2'd1;
	localparam logic [1:0] FORM_BULK  = 2'd2;
	localparam logic [1:0] FORM_PLAIN = 2'd3;

	logic [31:0]   max_bulk_len_q;
	logic [31:0]   max_elements_q;

	logic [2:0]    phase_q, phase_d;
	logic [1:0]    form_q, form_d;
	logic [31:0]   elements_left_q, elements_left_d;
	logic [AW-1:0] length_accum_q, length_accum_d;
	logic [31:0]   payload_left_q, payload_left_d;
	logic          prev_cr_q, prev_cr_d;
	logic          held_cr_q, held_cr_d;
	logic [31:0]   element_count_q, element_count_d;

	logic [VW-1:0] acc_v, prod_v, mask_v, reg_v, lim_v;
	logic          overflow;

	result_t       res [2];
	logic [1:0]    k;
	logic          go_idle;
	logic          err;
	logic          plain_go;
	logic          last_elem;

	assign deq = head_valid && room;

	// Next length value is accum * 10 + digit, built from two shifts.
	assign acc_v    = VW'(length_accum_q);
	assign prod_v   = (acc_v << 3) + (acc_v << 1) + VW'(head.digit);
	assign mask_v   = {{(VW-AW){1'b0}}, {AW{1'b1}}};
	assign reg_v    = VW'((form_q == FORM_ARRAY) ? max_elements_q : max_bulk_len_q);
	assign lim_v    = (reg_v < mask_v) ? reg_v : mask_v;
	assign overflow = (prod_v > lim_v);

	function automatic result_t mk(input logic [7:0] b, input logic has, input logic [31:0] idx,
			input logic ee, input logic me);
		result_t r;
		r.out_byte      = b;
		r.has_byte      = has;
		r.element_index = idx;
		r.element_end   = ee;
		r.message_end   = me;
		r.parse_error   = 1'b0;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	always_comb begin
		phase_d         = phase_q;
		form_d          = form_q;
		elements_left_d = elements_left_q;
		length_accum_d  = length_accum_q;
		payload_left_d  = payload_left_q;
		prev_cr_d       = prev_cr_q;
		held_cr_d       = held_cr_q;
		element_count_d = element_count_q;
		res[0]          = '0;
		res[1]          = '0;
		k               = 2'd0;
		go_idle         = 1'b0;
		err             = 1'b0;
		plain_go        = 1'b0;
		last_elem       = (elements_left_q <= 32'd1);

		if (deq) begin
			if (head.abandon) begin
				go_idle = 1'b1;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (head.is_star) begin
							form_d  = FORM_ARRAY;
							phase_d = PH_SIZE;
						end else if (head.is_dollar) begin
							form_d          = FORM_BULK;
							elements_left_d = 32'd1;
							phase_d         = PH_SIZE;
						end else if (head.is_letter) begin
							form_d  = FORM_PLAIN;
							phase_d = PH_PLAIN;
							res[0]  = mk(head.c, 1'b1, 32'd0, 1'b0, 1'b0);
							k       = 2'd1;
						end else if (!head.is_ws) begin
							err = 1'b1;
						end
					end
					PH_SIZE: begin
						if (prev_cr_q && !head.is_lf) begin
							err = 1'b1;
						end else if (head.is_cr) begin
							prev_cr_d = 1'b1;
						end else if (head.is_lf) begin
							prev_cr_d      = 1'b0;
							length_accum_d = '0;
							if (form_q == FORM_ARRAY) begin
								if (length_accum_q == '0) begin
									// An empty array is a whole message by itself.
									res[0]  = mk(8'd0, 1'b0, 32'd0, 1'b0, 1'b1);
									k       = 2'd1;
									go_idle = 1'b1;
								end else begin
									elements_left_d = 32'(length_accum_q);
									element_count_d = '0;
									form_d          = FORM_BULK;
									phase_d         = PH_MARK;
								end
							end else begin
								payload_left_d = 32'(length_accum_q);
								phase_d = (length_accum_q == '0) ? PH_TERM : PH_DATA;
							end
						end else if (head.is_digit) begin
							if (overflow) begin
								err = 1'b1;
							end else begin
								length_accum_d = prod_v[AW-1:0];
							end
						end else begin
							err = 1'b1;
						end
					end
					PH_MARK: begin
						if (head.is_dollar) begin
							length_accum_d = '0;
							prev_cr_d      = 1'b0;
							phase_d        = PH_SIZE;
						end else begin
							err = 1'b1;
						end
					end
					PH_DATA: begin
						res[0]         = mk(head.c, 1'b1, element_count_q, 1'b0, 1'b0);
						k              = 2'd1;
						payload_left_d = payload_left_q - 32'd1;
						if (payload_left_q == 32'd1) begin
							phase_d = PH_TERM;
						end
					end
					PH_TERM: begin
						if (head.is_cr && !prev_cr_q) begin
							prev_cr_d = 1'b1;
						end else if (head.is_lf) begin
							res[0]    = mk(8'd0, 1'b0, element_count_q, 1'b1, last_elem);
							k         = 2'd1;
							prev_cr_d = 1'b0;
							if (last_elem) begin
								go_idle = 1'b1;
							end else begin
								elements_left_d = elements_left_q - 32'd1;
								element_count_d = element_count_q + 32'd1;
								phase_d         = PH_MARK;
							end
						end else begin
							err = 1'b1;
						end
					end
					PH_PLAIN: begin
						plain_go = 1'b1;
						if (held_cr_q) begin
							held_cr_d = 1'b0;
							if (head.is_lf) begin
								res[0]   = mk(8'd0, 1'b0, element_count_q, 1'b1, 1'b1);
								k        = 2'd1;
								go_idle  = 1'b1;
								plain_go = 1'b0;
							end else begin
								// The held CR was data after all; it goes out first.
								res[0] = mk(CH_CR, 1'b1, element_count_q, 1'b0, 1'b0);
								k      = 2'd1;
							end
						end
						if (plain_go) begin
							if (head.is_sp) begin
								res[k[0]] = mk(8'd0, 1'b0, element_count_q, 1'b1, 1'b0);
								k         = k + 2'd1;
								element_count_d = element_count_q + 32'd1;
							end else if (head.is_lf) begin
								res[k[0]] = mk(8'd0, 1'b0, element_count_q, 1'b1, 1'b1);
								k         = k + 2'd1;
								go_idle   = 1'b1;
							end else if (head.is_cr) begin
								held_cr_d = 1'b1;
							end else begin
								res[k[0]] = mk(head.c, 1'b1, element_count_q, 1'b0, 1'b0);
								k         = k + 2'd1;
							end
						end
					end
					default: begin
						go_idle = 1'b1;
					end
				endcase
			end
		end

		if (err) begin
			res[0]             = '0;
			res[0].parse_error = 1'b1;
			k                  = 2'd1;
			go_idle            = 1'b1;
		end

		if (go_idle) begin
			phase_d         = PH_IDLE;
			form_d          = FORM_NONE;
			elements_left_d = '0;
			length_accum_d  = '0;
			payload_left_d  = '0;
			prev_cr_d       = 1'b0;
			held_cr_d       = 1'b0;
			element_count_d = '0;
		end

		if (k == 2'd1) begin
			res[0].last_of_run = 1'b1;
		end else if (k == 2'd2) begin
			res[1].last_of_run = 1'b1;
		end

		res_push.count = k;
		res_push.r0    = res[0];
		res_push.r1    = res[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bulk_len_q  <= MAX_BULK_LEN_RST;
			max_elements_q  <= MAX_ELEMENTS_RST;
			phase_q         <= PH_IDLE;
			form_q          <= FORM_NONE;
			elements_left_q <= '0;
			length_accum_q  <= '0;
			payload_left_q  <= '0;
			prev_cr_q       <= 1'b0;
			held_cr_q       <= 1'b0;
			element_count_q <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_MAX_BULK_LEN: max_bulk_len_q <= wr_data;
					REG_MAX_ELEMENTS: max_elements_q <= wr_data;
					default: ;
				endcase
			end
			phase_q         <= phase_d;
			form_q          <= form_d;
			elements_left_q <= elements_left_d;
			length_accum_q  <= length_accum_d;
			payload_left_q  <= payload_left_d;
			prev_cr_q       <= prev_cr_d;
			held_cr_q       <= held_cr_d;
			element_count_q <= element_count_d;
		end
	end

endmodule

// File: rtl/rrp_result_queue.sv
`timescale 1ns / 1ps

module rrp_result_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rrp_pkg::result_push_t  res_push,
	output logic                   room,
	input  logic                   pop,
	output logic                   empty,
	output rrp_pkg::result_t       head
);
	import rrp_pkg::*;

	result_t            entry_q [RES_DEPTH];
	logic [RPTR_W-1:0]  wr_ptr_q;
	logic [RPTR_W-1:0]  rd_ptr_q;
	logic [RPTR_W:0]    count_q;
	logic [RPTR_W-1:0]  wr_ptr_next;
	logic               do_pop;

	// Room means two free slots, enough for the worst case of one byte.
	assign room        = (count_q <= (RPTR_W+1)'(RES_DEPTH - 2));
	assign empty       = (count_q == '0);
	assign head        = entry_q[rd_ptr_q];
	assign do_pop      = pop && !empty;
	assign wr_ptr_next = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (res_push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= res_push.r0;
		end
		if (res_push.count == 2'd2) begin
			entry_q[wr_ptr_next] <= res_push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RPTR_W'(res_push.count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (RPTR_W+1)'(res_push.count) - (RPTR_W+1)'(do_pop);
		end
	end

endmodule

// File: rtl/rrp_checker.sv
`timescale 1ns / 1ps

module rrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  out_byte,
	input logic        has_byte,
	input logic [31:0] element_index,
	input logic        element_end,
	input logic        message_end,
	input logic        parse_error,
	input logic        last_of_run
);

	// An error result carries nothing else and closes the run of its byte.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && parse_error) |-> (!has_byte && !element_end && !message_end &&
			last_of_run && (element_index == 32'd0) && (out_byte == 8'd0)))
		else $error("error result carries other fields");

	// A message end is always the final result of its byte.
	a_msg_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && message_end) |-> (last_of_run && element_end ||
			last_of_run && !has_byte))
		else $error("message end not last of run");

	// Element ends and payload bytes never share a result.
	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && element_end) |-> !has_byte)
		else $error("element end with payload byte");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !has_byte) |-> (out_byte == 8'd0))
		else $error("out_byte nonzero without payload");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result vanished");

endmodule

bind resp_request_parser_core rrp_checker u_rrp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.out_byte      (out_byte),
	.has_byte      (has_byte),
	.element_index (element_index),
	.element_end   (element_end),
	.message_end   (message_end),
	.parse_error   (parse_error),
	.last_of_run   (last_of_run)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import rrp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_SIZE, PH_MARK, PH_DATA, PH_TERM, PH_PLAIN
	} parse_phase_e;

	typedef enum logic [1:0] {
		FORM_NONE, FORM_ARRAY, FORM_BULK, FORM_PLAIN
	} msg_form_e;

	typedef struct {
		logic [7:0] value;
		logic       drop;
	} stim_t;

	localparam int unsigned LONG_HOLD      = 80;
	localparam int unsigned SETTLE_CYCLES  = 10;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	// Tracks the parser state for every accepted byte and holds the results it must produce.
	class request_scoreboard;
		result_t      expected_results[$];
		int unsigned  mismatches;
		logic [31:0]  bulk_limit;
		logic [31:0]  count_limit;
		parse_phase_e phase;
		msg_form_e    form;
		logic [31:0]  elems_left;
		logic [31:0]  data_left;
		logic [31:0]  elem_idx;
		logic [63:0]  len_acc;
		logic         saw_cr;
		logic         cr_pending;
		result_t      step_buf[2];
		int unsigned  step_n;

		function new();
			mismatches  = 0;
			bulk_limit  = MAX_BULK_LEN_RST;
			count_limit = MAX_ELEMENTS_RST;
			go_idle();
		endfunction

		function void go_idle();
			phase      = PH_IDLE;
			form       = FORM_NONE;
			elems_left = '0;
			data_left  = '0;
			elem_idx   = '0;
			len_acc    = '0;
			saw_cr     = 1'b0;
			cr_pending = 1'b0;
		endfunction

		function void set_limit(logic [REG_INDEX_W-1:0] idx, logic [31:0] value);
			case (idx)
				REG_MAX_BULK_LEN: bulk_limit = value;
				REG_MAX_ELEMENTS: count_limit = value;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function void emit(logic [7:0] value, logic has, logic [31:0] idx,
				logic ee, logic me, logic err);
			result_t r;
			r.out_byte      = value;
			r.has_byte      = has;
			r.element_index = idx;
			r.element_end   = ee;
			r.message_end   = me;
			r.parse_error   = err;
			r.last_of_run   = 1'b0;
			step_buf[step_n] = r;
			step_n++;
		endfunction

		function void emit_error();
			go_idle();
			emit(8'h00, 1'b0, 32'd0, 1'b0, 1'b0, 1'b1);
		endfunction

		function void size_step(logic [7:0] c);
			logic [63:0] lim;
			logic [63:0] nxt;
			if (saw_cr && c != CH_LF) begin
				emit_error();
			end else if (c == CH_CR) begin
				saw_cr = 1'b1;
			end else if (c == CH_LF) begin
				saw_cr = 1'b0;
				if (form == FORM_ARRAY) begin
					if (len_acc == 0) begin
						// An empty array is a complete message by itself.
						emit(8'h00, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0);
						go_idle();
					end else begin
						elems_left = len_acc[31:0];
						elem_idx   = '0;
						form       = FORM_BULK;
						phase      = PH_MARK;
						len_acc    = '0;
					end
				end else begin
					data_left = len_acc[31:0];
					phase     = (data_left == 0) ? PH_TERM : PH_DATA;
					len_acc   = '0;
				end
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				lim = (form == FORM_ARRAY) ? {32'd0, count_limit} : {32'd0, bulk_limit};
				nxt = len_acc * 64'd10 + (c - CH_ZERO);
				if (nxt > lim)
					emit_error();
				else
					len_acc = nxt;
			end else begin
				emit_error();
			end
		endfunction

		function void plain_step(logic [7:0] c);
			if (cr_pending) begin
				cr_pending = 1'b0;
				if (c == CH_LF) begin
					emit(8'h00, 1'b0, elem_idx, 1'b1, 1'b1, 1'b0);
					go_idle();
					return;
				end
				emit(CH_CR, 1'b1, elem_idx, 1'b0, 1'b0, 1'b0);
			end
			if (c == CH_SP) begin
				emit(8'h00, 1'b0, elem_idx, 1'b1, 1'b0, 1'b0);
				elem_idx++;
			end else if (c == CH_LF) begin
				emit(8'h00, 1'b0, elem_idx, 1'b1, 1'b1, 1'b0);
				go_idle();
			end else if (c == CH_CR) begin
				cr_pending = 1'b1;
			end else begin
				emit(c, 1'b1, elem_idx, 1'b0, 1'b0, 1'b0);
			end
		endfunction

		function void note_byte(logic [7:0] c, logic drop);
			logic last;
			step_n = 0;
			if (drop) begin
				go_idle();
				return;
			end
			case (phase)
				PH_IDLE: begin
					if (c == CH_STAR) begin
						go_idle();
						form  = FORM_ARRAY;
						phase = PH_SIZE;
					end else if (c == CH_DOLLAR) begin
						go_idle();
						form       = FORM_BULK;
						elems_left = 32'd1;
						phase      = PH_SIZE;
					end else if ((c >= CH_UC_A && c <= CH_UC_Z) ||
							(c >= CH_LC_A && c <= CH_LC_Z)) begin
						go_idle();
						form  = FORM_PLAIN;
						phase = PH_PLAIN;
						emit(c, 1'b1, 32'd0, 1'b0, 1'b0, 1'b0);
					end else if (!(c == CH_SP || (c >= CH_TAB && c <= CH_CR))) begin
						emit_error();
					end
				end
				PH_SIZE: size_step(c);
				PH_MARK: begin
					if (c == CH_DOLLAR) begin
						len_acc = '0;
						saw_cr  = 1'b0;
						phase   = PH_SIZE;
					end else begin
						emit_error();
					end
				end
				PH_DATA: begin
					emit(c, 1'b1, elem_idx, 1'b0, 1'b0, 1'b0);
					data_left--;
					if (data_left == 0)
						phase = PH_TERM;
				end
				PH_TERM: begin
					if (c == CH_CR && !saw_cr) begin
						saw_cr = 1'b1;
					end else if (c == CH_LF) begin
						last = (elems_left <= 1);
						emit(8'h00, 1'b0, elem_idx, 1'b1, last, 1'b0);
						saw_cr = 1'b0;
						if (last) begin
							go_idle();
						end else begin
							elems_left--;
							elem_idx++;
							phase = PH_MARK;
						end
					end else begin
						emit_error();
					end
				end
				PH_PLAIN: plain_step(c);
				default: go_idle();
			endcase
			if (step_n > 0)
				step_buf[step_n-1].last_of_run = 1'b1;
			for (int i = 0; i < step_n; i++)
				expected_results = {expected_results, step_buf[i]};
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("%0t: mismatch: %s", $realtime, what);
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: %p", got));
				return;
			end
			want = expected_results.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte %0h, expected %0h",
					got.out_byte, want.out_byte));
			if (got.has_byte !== want.has_byte)
				report_mismatch($sformatf("has_byte %0b, expected %0b",
					got.has_byte, want.has_byte));
			if (got.element_index !== want.element_index)
				report_mismatch($sformatf("element_index %0d, expected %0d",
					got.element_index, want.element_index));
			if (got.element_end !== want.element_end)
				report_mismatch($sformatf("element_end %0b, expected %0b",
					got.element_end, want.element_end));
			if (got.message_end !== want.message_end)
				report_mismatch($sformatf("message_end %0b, expected %0b",
					got.message_end, want.message_end));
			if (got.parse_error !== want.parse_error)
				report_mismatch($sformatf("parse_error %0b, expected %0b",
					got.parse_error, want.parse_error));
			if (got.last_of_run !== want.last_of_run)
				report_mismatch($sformatf("last_of_run %0b, expected %0b",
					got.last_of_run, want.last_of_run));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	logic [7:0]             in_byte;
	logic                   abandon;
	logic                   wr_en;
	logic [REG_INDEX_W-1:0] wr_index;
	logic [31:0]            wr_data;
	logic                   empty;
	logic                   pop;
	logic [7:0]             out_byte;
	logic                   has_byte;
	logic [31:0]            element_index;
	logic                   element_end;
	logic                   message_end;
	logic                   parse_error;
	logic                   last_of_run;

	request_scoreboard sb;
	stim_t             stim_q[$];
	logic              bursts_on;
	logic              hold_request;
	int unsigned       quiet_cycles;

	resp_request_parser_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.in_byte       (in_byte),
		.abandon       (abandon),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.element_index (element_index),
		.element_end   (element_end),
		.message_end   (message_end),
		.parse_error   (parse_error),
		.last_of_run   (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Byte stream builders.
	function automatic void add_item(logic [7:0] value, logic drop);
		stim_t s;
		s.value = value;
		s.drop  = drop;
		stim_q  = {stim_q, s};
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], 1'b0);
	endfunction

	function automatic void add_term();
		if ($urandom_range(0, 1) == 0)
			add_item(CH_CR, 1'b0);
		add_item(CH_LF, 1'b0);
	endfunction

	function automatic void add_ws();
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 5) == 0)
				add_item(CH_SP, 1'b0);
			else
				add_item(CH_TAB + 8'($urandom_range(0, 4)), 1'b0);
		end
	endfunction

	function automatic void add_letter();
		int unsigned pick;
		pick = $urandom_range(0, 51);
		if (pick < 26)
			add_item(CH_UC_A + 8'(pick), 1'b0);
		else
			add_item(CH_LC_A + 8'(pick - 26), 1'b0);
	endfunction

	function automatic int unsigned capped_rand(logic [31:0] limit, int unsigned cap);
		return $urandom_range(0, (limit < cap) ? limit : cap);
	endfunction

	function automatic void add_count(int unsigned value);
		// A header with no digits reads as zero.
		if (value == 0 && $urandom_range(0, 3) == 0)
			return;
		if ($urandom_range(0, 5) == 0)
			add_item(CH_ZERO, 1'b0);
		add_text($sformatf("%0d", value));
	endfunction

	function automatic void add_oversize(logic [31:0] limit);
		logic [63:0] v;
		v = {32'd0, limit} + 64'd1;
		add_text($sformatf("%0d", v));
		add_term();
	endfunction

	function automatic void gen_bulk_body();
		int unsigned len;
		if ($urandom_range(0, 15) == 0) begin
			add_oversize(sb.bulk_limit);
			return;
		end
		len = capped_rand(sb.bulk_limit, 6);
		add_count(len);
		add_term();
		repeat (len) add_item(8'($urandom_range(0, 255)), 1'b0);
		add_term();
	endfunction

	function automatic void gen_array();
		int unsigned n;
		add_ws();
		add_item(CH_STAR, 1'b0);
		if ($urandom_range(0, 11) == 0) begin
			add_oversize(sb.count_limit);
			return;
		end
		n = capped_rand(sb.count_limit, 4);
		add_count(n);
		add_term();
		repeat (n) begin
			add_item(CH_DOLLAR, 1'b0);
			gen_bulk_body();
		end
	endfunction

	function automatic void gen_inline();
		add_ws();
		add_letter();
		repeat ($urandom_range(0, 8)) begin
			case ($urandom_range(0, 5))
				0, 1: add_letter();
				2: add_item(CH_SP, 1'b0);
				3: add_item(CH_CR, 1'b0);
				default: add_item(8'($urandom_range(0, 255)), 1'b0);
			endcase
		end
		add_term();
	endfunction

	function automatic void build_message();
		int unsigned kind;
		int unsigned pos;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			gen_array();
		end else if (kind <= 5) begin
			add_ws();
			add_item(CH_DOLLAR, 1'b0);
			gen_bulk_body();
		end else if (kind <= 8) begin
			gen_inline();
		end else begin
			repeat ($urandom_range(1, 4)) add_item(8'($urandom_range(0, 255)), 1'b0);
		end
		// Break a few messages: one corrupted byte, or an abandon on a random byte.
		pos = $urandom_range(0, stim_q.size() - 1);
		case ($urandom_range(0, 15))
			0, 1: stim_q[pos].value = 8'($urandom_range(0, 255));
			2: stim_q[pos].drop = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic void gen_directed();
		add_text("\011\013\014\015");
		add_text("a\015b c\015\012");
		add_item(8'hFF, 1'b0);
		add_text("*0\012");
		add_text("*1\015\012$\012");
		add_item(8'h00, 1'b0);
		add_text("$1\015\015");
		add_item(CH_DOLLAR, 1'b0);
		add_item(8'h55, 1'b1);
	endfunction

	// One input transaction; push stays high on return so back-to-back bytes need no gap.
	task automatic send_item(input logic [7:0] value, input logic drop);
		if (bursts_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		push    <= 1'b1;
		in_byte <= value;
		abandon <= drop;
		do @(posedge clk); while (full);
		sb.note_byte(value, drop);
	endtask

	task automatic send_all();
		stim_t s;
		while (stim_q.size() > 0) begin
			s = stim_q.pop_front();
			send_item(s.value, s.drop);
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned n_bytes);
		int unsigned sent;
		sent = 0;
		while (sent < n_bytes) begin
			build_message();
			sent += stim_q.size();
			send_all();
		end
		// Leave the parser idle before the limits change.
		add_item(8'($urandom_range(0, 255)), 1'b1);
		send_all();
		settle();
	endtask

	task automatic write_limits(input logic [31:0] bulk, input logic [31:0] count);
		wr_en    <= 1'b1;
		wr_index <= REG_MAX_BULK_LEN;
		wr_data  <= bulk;
		@(posedge clk);
		wr_index <= REG_MAX_ELEMENTS;
		wr_data  <= count;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.set_limit(REG_MAX_BULK_LEN, bulk);
		sb.set_limit(REG_MAX_ELEMENTS, count);
	endtask

	initial begin
		sb           = new();
		bursts_on    = 1'b1;
		hold_request = 1'b0;
		push     <= 1'b0;
		in_byte  <= 8'h00;
		abandon  <= 1'b0;
		wr_en    <= 1'b0;
		wr_index <= REG_MAX_BULK_LEN;
		wr_data  <= '0;
		arst_n   <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gen_directed();
		send_all();
		settle();

		hold_request = 1'b1;
		random_phase(120);
		write_limits(32'd0, 32'd1);
		random_phase(120);
		write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(120);
		write_limits(32'($urandom_range(1, 8)), 32'($urandom_range(2, 5)));
		bursts_on = 1'b0;
		random_phase(120);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Result side: check each popped transaction; stall in bursts and, on request, for one long hold.
	initial begin
		int unsigned stall_left;
		result_t     got;
		stall_left = 0;
		pop <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.out_byte      = out_byte;
				got.has_byte      = has_byte;
				got.element_index = element_index;
				got.element_end   = element_end;
				got.message_end   = message_end;
				got.parse_error   = parse_error;
				got.last_of_run   = last_of_run;
				sb.check_result(got);
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (hold_request) begin
				// Long hold so that both queues fill and full rises.
				hold_request = 1'b0;
				stall_left   = LONG_HOLD - 1;
				pop <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 11);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule

// File: files.f
rtl/rrp_pkg.sv
rtl/rrp_front.sv
rtl/rrp_back.sv
rtl/rrp_result_queue.sv
rtl/resp_request_parser_core.sv
rtl/rrp_checker.sv
tb/tb.sv
